FILE: sv/lzwe_pkg.sv
// Package for the LZ window byte encoder: constants, codes, phase and
// controller state types, and the command/status bundles.
// No dependencies.
package lzwe_pkg;

   localparam int STORE_DEPTH = 384;
   localparam int KEEP_BEHIND = 256;
   localparam int MAX_OFFSET  = 255;
   localparam int MAX_RUN     = 127;
   localparam int MIN_MATCH   = 4;
   localparam int MATCH_BASE  = 128;
   localparam int ADDR_W      = 9;
   localparam logic [16:0] LIMIT_RESET = 17'h10000;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_PULL = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_BYTE    = 3'd2;
   localparam logic [2:0] ST_NEED    = 3'd3;
   localparam logic [2:0] ST_FINISHED = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE, PH_MLEN, PH_MOFF, PH_LCNT, PH_LBYT, PH_TERM, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      C_IDLE, C_SLIDE, C_CHECK, C_MINIT, C_OFFSET, C_MREAD, C_MCMP, C_MEND,
      C_MDEC, C_LREAD, C_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic slide;
      logic check_resp;
      logic plan_init;
      logic match_init;
      logic j_clear;
      logic cmp_read;
      logic j_inc;
      logic offset_done;
      logic lit_end;
      logic match_decide;
      logic lit_read;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic phase_idle;
      logic done_cond;
      logic need_cond;
      logic scan_more;
      logic off_more;
      logic run_more;
      logic bytes_equal;
      logic best_ge_min;
   } stat_type;

   // Map a logical store index onto the circular physical store.
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] x);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, x};
      if (sum >= (ADDR_W+1)'(STORE_DEPTH))
         sum = sum - (ADDR_W+1)'(STORE_DEPTH);
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: sv/lz_window_byte_encoder.sv
// LZ window byte encoder, top level: controller plus datapath.
// Push, end and no-op beats: the response is valid right after the accepting edge.
// A pull with no token search responds after the slide and check states, or the
// literal-read and emit states mid-token. A token search visits up to 255 offsets
// and 127 bytes per offset per scanned position. One beat in flight at a time:
// the next request is taken the cycle after the response beat leaves.
// Reset (synchronous, active high) empties the window; the store needs no clearing.
module lz_window_byte_encoder import lzwe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_stream_last,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);
   // Command and status bundles between sequencer and datapath.
   cmd_type  cmd;
   stat_type stat;

   // Sequence each beat: accept, slide, search, emit.
   lzwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_opcode(req_opcode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the window, pointers and result register.
   lzwe_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_stream_last(rsp_stream_last)
   );
endmodule

FILE: sv/lzwe_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module lzwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

FILE: sv/lzwe_ctrl.sv
// Controller state machine of the LZ window byte encoder.
// Depends on lzwe_pkg.
module lzwe_ctrl import lzwe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);
   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= C_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != C_IDLE) || stat.rsp_busy;
      case (state_ff)
         C_IDLE: begin
            if (req_valid && !stat.rsp_busy) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_PULL)
                  state_in = stat.phase_idle ? C_SLIDE : C_LREAD;
            end
         end
         C_SLIDE: begin
            cmd.slide = 1'b1;
            state_in  = C_CHECK;
         end
         C_CHECK: begin
            cmd.check_resp = 1'b1;
            if (!stat.done_cond && !stat.need_cond) begin
               cmd.plan_init = 1'b1;
               state_in      = C_MINIT;
            end else begin
               state_in = C_IDLE;
            end
         end
         C_MINIT: begin
            if (stat.scan_more) begin
               cmd.match_init = 1'b1;
               state_in       = C_OFFSET;
            end else begin
               cmd.lit_end = 1'b1;
               state_in    = C_LREAD;
            end
         end
         C_OFFSET: begin
            if (stat.off_more) begin
               cmd.j_clear = 1'b1;
               state_in    = C_MREAD;
            end else begin
               state_in = C_MDEC;
            end
         end
         C_MREAD: begin
            if (stat.run_more) begin
               cmd.cmp_read = 1'b1;
               state_in     = C_MCMP;
            end else begin
               state_in = C_MEND;
            end
         end
         C_MCMP: begin
            if (stat.bytes_equal) begin
               cmd.j_inc = 1'b1;
               state_in  = C_MREAD;
            end else begin
               state_in = C_MEND;
            end
         end
         C_MEND: begin
            cmd.offset_done = 1'b1;
            state_in        = C_OFFSET;
         end
         C_MDEC: begin
            cmd.match_decide = 1'b1;
            state_in = stat.best_ge_min ? C_LREAD : C_MINIT;
         end
         C_LREAD: begin
            cmd.lit_read = 1'b1;
            state_in     = C_EMIT;
         end
         C_EMIT: begin
            cmd.emit = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end
endmodule

FILE: sv/lzwe_datapath.sv
// Datapath of the LZ window byte encoder: store, window pointers, match
// search registers and the result register. Depends on lzwe_pkg, lzwe_ram.
module lzwe_datapath import lzwe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_stream_last
);
   logic [16:0] limit_ff, limit_in, taken_ff, taken_in;
   logic [ADDR_W-1:0] base_ff, base_in, scan_ff, scan_in, fill_ff, fill_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic ended_ff, ended_in;
   phase_type phase_ff, phase_in;
   logic [6:0] eidx_ff, eidx_in, tlen_ff, tlen_in, count_ff, count_in;
   logic [6:0] j_ff, j_in, best_ff, best_in;
   logic [7:0] toff_ff, toff_in, boff_ff, boff_in, top_ff, top_in;
   logic [8:0] off_ff, off_in;
   logic rv_ff, rv_in, last_ff, last_in;
   logic [2:0] st_ff, st_in;
   logic [7:0] ob_ff, ob_in;

   logic more, wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_a, rd_b, lit_idx, cand_idx, cur_idx, shift;
   logic [ADDR_W:0] pos_j;
   logic [7:0] rd_data_a, rd_data_b;
   logic finish_term;

   assign more     = !ended_ff && (taken_ff < limit_ff);
   assign pos_j    = {1'b0, pos_ff} + (ADDR_W+1)'(j_ff);
   assign cur_idx  = pos_j[ADDR_W-1:0];
   assign cand_idx = ADDR_W'(pos_j - (ADDR_W+1)'(off_ff));
   assign lit_idx  = scan_ff - ADDR_W'(tlen_ff) + ADDR_W'(eidx_ff);
   assign shift    = scan_ff - ADDR_W'(KEEP_BEHIND);
   assign wr_addr  = phys_addr(base_ff, fill_ff);
   assign rd_a     = phys_addr(base_ff, cmd.lit_read ? lit_idx : cand_idx);
   assign rd_b     = phys_addr(base_ff, cur_idx);
   assign finish_term = (scan_ff >= fill_ff) && !more;

   lzwe_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_data_byte),
      .rd_addr_a(rd_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_b),
      .rd_data_b(rd_data_b)
   );

   always_comb begin
      stat.rsp_busy    = rv_ff;
      stat.phase_idle  = (phase_ff == PH_IDLE);
      stat.done_cond   = (scan_ff >= fill_ff) && !more;
      stat.need_cond   = ((fill_ff < ADDR_W'(STORE_DEPTH)) && more) || (scan_ff >= fill_ff);
      stat.scan_more   = (count_ff < 7'(MAX_RUN)) && (pos_ff < fill_ff);
      stat.off_more    = (off_ff <= {1'b0, top_ff});
      stat.run_more    = (j_ff < 7'(MAX_RUN)) && (pos_j < {1'b0, fill_ff});
      stat.bytes_equal = (rd_data_a == rd_data_b);
      stat.best_ge_min = (best_ff >= 7'(MIN_MATCH));
   end

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      taken_in = taken_ff;  base_in = base_ff;  scan_in = scan_ff;
      fill_in  = fill_ff;   pos_in  = pos_ff;   ended_in = ended_ff;
      phase_in = phase_ff;  eidx_in = eidx_ff;  tlen_in = tlen_ff;
      count_in = count_ff;  j_in = j_ff;        best_in = best_ff;
      toff_in  = toff_ff;   boff_in = boff_ff;  top_in = top_ff;
      off_in   = off_ff;
      rv_in    = rv_ff && rsp_stall;
      st_in    = st_ff;  ob_in = ob_ff;  last_in = last_ff;
      wr_en    = 1'b0;

      if (cmd.accept && req_opcode != OP_PULL) begin
         rv_in = 1'b1;  st_in = ST_OK;  ob_in = 8'd0;  last_in = 1'b0;
         if (req_opcode == OP_END) begin
            ended_in = 1'b1;
         end else if (req_opcode == OP_PUSH && phase_ff != PH_DONE && more) begin
            if (fill_ff >= ADDR_W'(STORE_DEPTH)) begin
               st_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               fill_in  = fill_ff + 1'b1;
               taken_in = taken_ff + 1'b1;
            end
         end
      end
      // Slide the window by moving the base, not the data.
      if (cmd.slide && scan_ff > ADDR_W'(KEEP_BEHIND) && scan_ff <= fill_ff) begin
         base_in = phys_addr(base_ff, shift);
         fill_in = fill_ff - shift;
         scan_in = ADDR_W'(KEEP_BEHIND);
      end
      if (cmd.check_resp) begin
         ob_in = 8'd0;  last_in = 1'b0;
         if (stat.done_cond) begin
            phase_in = PH_DONE;  rv_in = 1'b1;  st_in = ST_FINISHED;
         end else if (stat.need_cond) begin
            rv_in = 1'b1;  st_in = ST_NEED;
         end
      end
      if (cmd.plan_init) begin
         pos_in = scan_ff;  count_in = 7'd0;
      end
      if (cmd.match_init) begin
         off_in  = 9'd1;  best_in = 7'd0;  boff_in = 8'd0;
         top_in  = (pos_ff < ADDR_W'(MAX_OFFSET)) ? pos_ff[7:0] : 8'(MAX_OFFSET);
      end
      if (cmd.j_clear) j_in = 7'd0;
      if (cmd.j_inc)   j_in = j_ff + 1'b1;
      if (cmd.offset_done) begin
         if (j_ff > best_ff) begin
            best_in = j_ff;  boff_in = off_ff[7:0];
         end
         off_in = off_ff + 1'b1;
      end
      if (cmd.lit_end) begin
         tlen_in = count_ff;  scan_in = pos_ff;  phase_in = PH_LCNT;
      end
      if (cmd.match_decide) begin
         if (stat.best_ge_min) begin
            if (count_ff != 7'd0) begin
               tlen_in = count_ff;  scan_in = pos_ff;  phase_in = PH_LCNT;
            end else begin
               tlen_in  = best_ff;  toff_in = boff_ff;
               scan_in  = pos_ff + ADDR_W'(best_ff);
               phase_in = PH_MLEN;
            end
         end else begin
            pos_in   = pos_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         rv_in = 1'b1;  st_in = ST_BYTE;  last_in = 1'b0;  ob_in = 8'd0;
         case (phase_ff)
            PH_MLEN: begin
               ob_in = 8'(MATCH_BASE) + {1'b0, tlen_ff};  phase_in = PH_MOFF;
            end
            PH_MOFF: begin
               ob_in = toff_ff;  phase_in = finish_term ? PH_TERM : PH_IDLE;
            end
            PH_LCNT: begin
               ob_in = {1'b0, tlen_ff};  eidx_in = 7'd0;  phase_in = PH_LBYT;
            end
            PH_LBYT: begin
               ob_in   = rd_data_a;
               eidx_in = eidx_ff + 1'b1;
               if (eidx_ff + 7'd1 >= tlen_ff)
                  phase_in = finish_term ? PH_TERM : PH_IDLE;
            end
            PH_TERM: begin
               last_in = 1'b1;  phase_in = PH_DONE;
            end
            default: begin
               st_in = ST_FINISHED;  phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;  taken_ff <= '0;  base_ff <= '0;
         scan_ff  <= '0;  fill_ff <= '0;  ended_ff <= 1'b0;
         phase_ff <= PH_IDLE;  eidx_ff <= '0;  tlen_ff <= '0;  toff_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         limit_ff <= limit_in;  taken_ff <= taken_in;  base_ff <= base_in;
         scan_ff  <= scan_in;   fill_ff <= fill_in;    ended_ff <= ended_in;
         phase_ff <= phase_in;  eidx_ff <= eidx_in;    tlen_ff <= tlen_in;
         toff_ff  <= toff_in;   rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;  count_ff <= count_in;  j_ff <= j_in;  best_ff <= best_in;
      boff_ff <= boff_in;  top_ff <= top_in;  off_ff <= off_in;
      st_ff <= st_in;  ob_ff <= ob_in;  last_ff <= last_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_out_byte    = ob_ff;
   assign rsp_stream_last = last_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ADDR_W'(STORE_DEPTH)) else $error("fill beyond store");
   a_scan_fill: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= fill_ff) else $error("scan past fill");
   a_base_bound: assert property (@(posedge clock) disable iff (reset)
      base_ff < ADDR_W'(STORE_DEPTH)) else $error("base out of range");
   a_last_term: assert property (@(posedge clock) disable iff (reset)
      rv_ff && last_ff |-> st_ff == ST_BYTE && ob_ff == 8'd0 && phase_ff == PH_DONE)
      else $error("bad terminator beat");
`endif
endmodule
